// ===== hdl/rgb_to_hsv_converter_defines.svh =====
// ----------------------------------------------------------------------------
// rgb to hsv converter assertion macros
// shared property shorthands for the converter's checks
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// same-cycle implication under active-low reset
`define RHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active-low reset
`define RHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb to hsv converter package
// widths, stage counts and pipeline record types
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FRAC_BITS      = 16;
    localparam int HUE_BITS       = FRAC_BITS;
    localparam int SAT_BITS       = FRAC_BITS + 1;
    // remainder and divisor width for the hue divide (six times delta)
    localparam int HUE_DIV_BITS   = COMPONENT_BITS + 3;
    localparam int DIV_STEPS      = FRAC_BITS;
    localparam int FRONT_STAGES   = 3;
    localparam int NUM_STAGES     = FRONT_STAGES + DIV_STEPS + 1;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
        logic [COMPONENT_BITS-1:0] hi;
        logic [COMPONENT_BITS-1:0] lo;
        t_sector                   sector;
    } t_ext;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0]        hi;
        logic [COMPONENT_BITS-1:0]        delta;
        logic signed [COMPONENT_BITS:0]   diff;
        t_sector                          sector;
    } t_dif;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] hi;
        logic [COMPONENT_BITS-1:0] sat_rem;
        logic [SAT_BITS-1:0]       sat_q;
        logic [HUE_DIV_BITS-1:0]   hue_rem;
        logic [HUE_DIV_BITS-1:0]   six;
        logic [HUE_BITS-1:0]       hue_q;
        logic                      hi_zero;
        logic                      delta_zero;
    } t_div;

endpackage

// ===== hdl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb to hsv converter
// pipelined pixel color space conversion, while unstalled one pixel per clock
// ----------------------------------------------------------------------------
// usage
// - input channel: i_valid with i_red_in / i_green_in / i_blue_in, the block
//   drives o_stall; a request is taken on a rising edge with i_valid high
//   and o_stall low
// - output channel: o_valid with o_hue_out / o_saturation_out / o_value_out,
//   the receiver drives i_stall; a request is delivered on an edge with
//   o_valid high and i_stall low
// - 20 register stages: input register, max/min, delta and difference,
//   divide setup, then 16 restoring divide steps that form hue and
//   saturation one quotient bit per stage each
// - o_valid rises once the accepted pixel has passed every stage in order;
//   throughput one pixel per cycle when unstalled, set by the one-bit divides
// - a stalled output holds its request; empty stages behind it keep
//   filling, so the input is stalled only once every stage holds a pixel
// - reset (synchronous, active low) empties every stage; no other state
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [rhc_pkg::COMPONENT_BITS-1:0]  i_red_in,
    input  logic [rhc_pkg::COMPONENT_BITS-1:0]  i_green_in,
    input  logic [rhc_pkg::COMPONENT_BITS-1:0]  i_blue_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rhc_pkg::HUE_BITS-1:0]        o_hue_out,
    output logic [rhc_pkg::SAT_BITS-1:0]        o_saturation_out,
    output logic [rhc_pkg::COMPONENT_BITS-1:0]  o_value_out
);
    import rhc_pkg::*;
    `include "rgb_to_hsv_converter_defines.svh"

    localparam int CB = COMPONENT_BITS;

    // stage valid bits, stage 0 is the input register
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    // load enable per stage
    logic [NUM_STAGES-1:0] stage_en;

    t_pix r_s1;
    t_ext r_s2, n_s2;
    t_dif r_s3, n_s3;
    t_div r_div [0:DIV_STEPS];
    // setup stage next value, then one next value per divide step
    t_div n_div0;
    t_div n_div [1:DIV_STEPS];

    // divide step scratch
    logic [CB:0]             sat_trial [1:DIV_STEPS];
    logic                    sat_bit   [1:DIV_STEPS];
    logic [HUE_DIV_BITS:0]   hue_trial [1:DIV_STEPS];
    logic                    hue_bit   [1:DIV_STEPS];

    // setup stage scratch
    logic [HUE_DIV_BITS-1:0] delta_ext;
    logic [HUE_DIV_BITS-1:0] delta_x2;
    logic [HUE_DIV_BITS-1:0] delta_x4;
    logic [HUE_DIV_BITS-1:0] six_delta;
    logic [HUE_DIV_BITS-1:0] hue_base;
    logic [HUE_DIV_BITS-1:0] diff_ext;
    logic                    sat_int;

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or when everything
    // ahead of it moves; bubbles collapse behind a stalled output
    // ------------------------------------------------------------------
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    always_comb begin
        n_valid[0] = stage_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = stage_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !stage_en[0];

    // ------------------------------------------------------------------
    // stage 1: max, min and the winning sector (red, then green, then blue)
    // ------------------------------------------------------------------
    always_comb begin
        n_s2.red   = r_s1.red;
        n_s2.green = r_s1.green;
        n_s2.blue  = r_s1.blue;
        n_s2.hi    = (r_s1.red > r_s1.green) ? r_s1.red : r_s1.green;
        if (r_s1.blue > n_s2.hi) begin
            n_s2.hi = r_s1.blue;
        end
        n_s2.lo    = (r_s1.red < r_s1.green) ? r_s1.red : r_s1.green;
        if (r_s1.blue < n_s2.lo) begin
            n_s2.lo = r_s1.blue;
        end
        if (r_s1.red == n_s2.hi) begin
            n_s2.sector = SEC_RED;
        end else if (r_s1.green == n_s2.hi) begin
            n_s2.sector = SEC_GREEN;
        end else begin
            n_s2.sector = SEC_BLUE;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: delta and the signed component difference of the sector
    // ------------------------------------------------------------------
    always_comb begin
        n_s3.hi     = r_s2.hi;
        n_s3.delta  = r_s2.hi - r_s2.lo;
        n_s3.sector = r_s2.sector;
        case (r_s2.sector)
            SEC_RED:   n_s3.diff = $signed({1'b0, r_s2.green}) - $signed({1'b0, r_s2.blue});
            SEC_GREEN: n_s3.diff = $signed({1'b0, r_s2.blue}) - $signed({1'b0, r_s2.red});
            SEC_BLUE:  n_s3.diff = $signed({1'b0, r_s2.red}) - $signed({1'b0, r_s2.green});
            default:   n_s3.diff = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage 3: divide setup
    // hue numerator = sector offset in units of delta plus the difference,
    // wrapped by six delta in the red sector when negative; for nonzero delta
    // it lands in 0 .. 6*delta-1. saturation integer bit is delta >= max
    // ------------------------------------------------------------------
    always_comb begin
        delta_ext = HUE_DIV_BITS'(r_s3.delta);
        delta_x2  = delta_ext << 1;
        delta_x4  = delta_ext << 2;
        six_delta = delta_x2 + delta_x4;
        diff_ext  = {{(HUE_DIV_BITS-CB-1){r_s3.diff[CB]}}, r_s3.diff};
        case (r_s3.sector)
            SEC_RED:   hue_base = r_s3.diff[CB] ? six_delta : '0;
            SEC_GREEN: hue_base = delta_x2;
            SEC_BLUE:  hue_base = delta_x4;
            default:   hue_base = '0;
        endcase
        sat_int = (r_s3.delta >= r_s3.hi);

        n_div0.hi         = r_s3.hi;
        n_div0.sat_rem    = sat_int ? (r_s3.delta - r_s3.hi) : r_s3.delta;
        n_div0.sat_q      = SAT_BITS'(sat_int);
        n_div0.hue_rem    = hue_base + diff_ext;
        n_div0.six        = six_delta;
        n_div0.hue_q      = '0;
        n_div0.hi_zero    = (r_s3.hi == '0);
        n_div0.delta_zero = (r_s3.delta == '0);
    end

    // ------------------------------------------------------------------
    // divide stages: one restoring step per stage for each quotient;
    // the last stage clears hue for grey and saturation for black
    // ------------------------------------------------------------------
    always_comb begin
        for (int j = 1; j <= DIV_STEPS; j++) begin
            sat_trial[j] = {r_div[j-1].sat_rem, 1'b0};
            sat_bit[j]   = (sat_trial[j] >= {1'b0, r_div[j-1].hi});
            hue_trial[j] = {r_div[j-1].hue_rem, 1'b0};
            hue_bit[j]   = (hue_trial[j] >= {1'b0, r_div[j-1].six});

            n_div[j]         = r_div[j-1];
            n_div[j].sat_rem = sat_bit[j]
                             ? CB'(sat_trial[j] - {1'b0, r_div[j-1].hi})
                             : CB'(sat_trial[j]);
            n_div[j].sat_q   = {r_div[j-1].sat_q[SAT_BITS-2:0], sat_bit[j]};
            n_div[j].hue_rem = hue_bit[j]
                             ? HUE_DIV_BITS'(hue_trial[j] - {1'b0, r_div[j-1].six})
                             : HUE_DIV_BITS'(hue_trial[j]);
            n_div[j].hue_q   = {r_div[j-1].hue_q[HUE_BITS-2:0], hue_bit[j]};

            if (j == DIV_STEPS) begin
                if (r_div[j-1].hi_zero) begin
                    n_div[j].sat_q = '0;
                end
                if (r_div[j-1].delta_zero) begin
                    n_div[j].hue_q = '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers, loaded with their stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1.red   <= i_red_in;
            r_s1.green <= i_green_in;
            r_s1.blue  <= i_blue_in;
        end
        if (stage_en[1]) begin
            r_s2 <= n_s2;
        end
        if (stage_en[2]) begin
            r_s3 <= n_s3;
        end
        if (stage_en[FRONT_STAGES]) begin
            r_div[0] <= n_div0;
        end
        for (int j = 1; j <= DIV_STEPS; j++) begin
            if (stage_en[FRONT_STAGES + j]) begin
                r_div[j] <= n_div[j];
            end
        end
    end

    assign o_valid          = r_valid[NUM_STAGES-1];
    assign o_hue_out        = r_div[DIV_STEPS].hue_q;
    assign o_saturation_out = r_div[DIV_STEPS].sat_q;
    assign o_value_out      = r_div[DIV_STEPS].hi;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `RHC_ASSERT_IMP(a_black_is_zero, i_clk, i_rst_n,
        o_valid && (o_value_out == '0), (o_saturation_out == '0) && (o_hue_out == '0),
        "black pixel with nonzero hue or saturation")
    `RHC_ASSERT_IMP(a_sat_at_most_one, i_clk, i_rst_n,
        o_valid && o_saturation_out[SAT_BITS-1], o_saturation_out[SAT_BITS-2:0] == '0,
        "saturation above full scale")
    `RHC_ASSERT_NXT(a_accept_fills_input, i_clk, i_rst_n,
        i_valid && !o_stall, r_valid[0],
        "accepted request not held in input stage")

endmodule

// ===== tb/sv/tb_rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb to hsv converter testbench
// drives pixels through the valid/stall input channel with random gaps or none,
// applies random or no back pressure on the output channel and checks every
// hue, saturation and value result against an integer hsv predictor
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;

    import rhc_pkg::*;

    localparam int CB = COMPONENT_BITS;

    // sender gap and receiver stall profiles
    typedef enum {GAP_NONE, GAP_NORMAL} t_gap_mode;
    typedef enum {STALL_NONE, STALL_NORMAL, STALL_HEAVY} t_stall_mode;

    // one expected result, plus the sector it came from for the summary
    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [SAT_BITS-1:0] sat;
        logic [CB-1:0]       val;
        t_sector             sector;
        logic                flat;
    } t_hsv_expect;

    // ports
    logic                i_clk;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                o_stall;
    logic [CB-1:0]       i_red_in         = '0;
    logic [CB-1:0]       i_green_in       = '0;
    logic [CB-1:0]       i_blue_in        = '0;
    logic                o_valid;
    logic                i_stall          = 1'b0;
    logic [HUE_BITS-1:0] o_hue_out;
    logic [SAT_BITS-1:0] o_saturation_out;
    logic [CB-1:0]       o_value_out;

    // expected results in request order
    t_hsv_expect pending_hsv[$];

    t_gap_mode   gap_mode   = GAP_NORMAL;
    t_stall_mode stall_mode = STALL_NORMAL;

    int mismatch_count  = 0;
    int checked_count   = 0;
    int sent_count      = 0;
    int flat_count      = 0;
    int in_stall_cycles = 0;
    int sector_count[3] = '{0, 0, 0};

    rgb_to_hsv_converter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hue_out        (o_hue_out),
        .o_saturation_out (o_saturation_out),
        .o_value_out      (o_value_out)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hsv of one pixel, exact integer math with truncating divides
    function automatic t_hsv_expect predict_hsv(logic [CB-1:0] r, logic [CB-1:0] g,
                                                logic [CB-1:0] b);
        logic [63:0] red, green, blue, hi, lo, delta, six, num, quo;
        t_hsv_expect res;
        red   = 64'(r);
        green = 64'(g);
        blue  = 64'(b);
        hi    = (red > green) ? red : green;
        hi    = (hi > blue) ? hi : blue;
        lo    = (red < green) ? red : green;
        lo    = (lo < blue) ? lo : blue;
        delta = hi - lo;
        res   = '0;
        res.val  = hi[CB-1:0];
        res.flat = (delta == 0);
        // red checked first, then green, so ties go to the earlier one
        if (red == hi)
            res.sector = SEC_RED;
        else if (green == hi)
            res.sector = SEC_GREEN;
        else
            res.sector = SEC_BLUE;
        // black pixel leaves saturation at zero
        if (hi != 0) begin
            quo = (delta << 16) / hi;
            res.sat = quo[SAT_BITS-1:0];
        end
        // grey pixel leaves hue at zero
        if (delta != 0) begin
            six = 6 * delta;
            case (res.sector)
                SEC_RED: begin
                    // negative green - blue wraps by a full turn
                    if (green >= blue)
                        num = green - blue;
                    else
                        num = six - (blue - green);
                end
                SEC_GREEN: num = 2 * delta + blue - red;
                default:   num = 4 * delta + red - green;
            endcase
            quo = (num << 16) / six;
            res.hue = quo[HUE_BITS-1:0];
        end
        return res;
    endfunction

    // idle cycles before the next request, mostly short
    function automatic int gap_cycles();
        int pick;
        if (gap_mode == GAP_NONE)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // one request: optional gap, then hold until the block takes it
    task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                              input logic [CB-1:0] b);
        int gap;
        t_hsv_expect want;
        gap = gap_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (o_stall);
        want = predict_hsv(r, g, b);
        pending_hsv.push_back(want);
        sent_count++;
        if (want.flat)
            flat_count++;
        else
            sector_count[want.sector]++;
    endtask

    // random pixel, biased toward ties, near-grey and extreme components
    task automatic random_pixel(output logic [CB-1:0] r, output logic [CB-1:0] g,
                                output logic [CB-1:0] b);
        logic [CB-1:0] top, low;
        int span;
        r   = CB'($urandom);
        g   = CB'($urandom);
        b   = CB'($urandom);
        top = CB'($urandom);
        low = CB'($urandom_range(0, top));
        case ($urandom_range(0, 9))
            0: begin
                // two components share the maximum
                case ($urandom_range(0, 2))
                    0: begin r = top; g = top; b = low; end
                    1: begin r = top; g = low; b = top; end
                    default: begin r = low; g = top; b = top; end
                endcase
            end
            1: begin
                // near grey, delta of a few codes
                span = $urandom_range(0, 3);
                g = r + CB'($urandom_range(0, span));
                b = r + CB'($urandom_range(0, span));
                if (g < r) g = r;
                if (b < r) b = r;
            end
            2: begin
                // one component pinned at an extreme
                case ($urandom_range(0, 2))
                    0: r = $urandom_range(0, 1) ? '1 : '0;
                    1: g = $urandom_range(0, 1) ? '1 : '0;
                    default: b = $urandom_range(0, 1) ? '1 : '0;
                endcase
            end
            3: begin
                // small values, dark pixels
                r = CB'($urandom_range(0, 7));
                g = CB'($urandom_range(0, 7));
                b = CB'($urandom_range(0, 7));
            end
            default: ;
        endcase
    endtask

    // receiver back pressure, driven at the rising edge
    initial begin
        int run_len, hold_len;
        forever begin
            case (stall_mode)
                STALL_NONE: begin
                    run_len  = 8;
                    hold_len = 0;
                end
                STALL_HEAVY: begin
                    run_len  = $urandom_range(1, 3);
                    hold_len = $urandom_range(10, 40);
                end
                default: begin
                    run_len = $urandom_range(1, 8);
                    case ($urandom_range(0, 19))
                        0:       hold_len = $urandom_range(25, 50);
                        1, 2, 3,
                        4, 5:    hold_len = $urandom_range(3, 8);
                        default: hold_len = $urandom_range(0, 2);
                    endcase
                end
            endcase
            i_stall <= 1'b0;
            repeat (run_len) @(posedge i_clk);
            if (hold_len > 0) begin
                i_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
            end
        end
    end

    // result checker, one delivered request per edge at most
    always @(posedge i_clk) begin
        t_hsv_expect want;
        if (i_rst_n && i_valid && o_stall)
            in_stall_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hsv.size() == 0) begin
                $display("%0t: unexpected result hue %h sat %h value %h", $time,
                         o_hue_out, o_saturation_out, o_value_out);
                mismatch_count++;
            end else begin
                want = pending_hsv.pop_front();
                checked_count++;
                if (o_hue_out !== want.hue) begin
                    $display("%0t: hue mismatch expected %h actual %h", $time,
                             want.hue, o_hue_out);
                    mismatch_count++;
                end
                if (o_saturation_out !== want.sat) begin
                    $display("%0t: saturation mismatch expected %h actual %h", $time,
                             want.sat, o_saturation_out);
                    mismatch_count++;
                end
                if (o_value_out !== want.val) begin
                    $display("%0t: value mismatch expected %h actual %h", $time,
                             want.val, o_value_out);
                    mismatch_count++;
                end
            end
        end
    end

    // black, white, greys, the pure primaries and some mixed pixels
    task automatic test_extremes();
        gap_mode   = GAP_NORMAL;
        stall_mode = STALL_NORMAL;
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'h0001, 16'h0001, 16'h0001);
        send_pixel('1, '0, '0);
        send_pixel('0, '1, '0);
        send_pixel('0, '0, '1);
        send_pixel(16'h0001, '0, '0);
        send_pixel('1, 16'hfffe, 16'hfffe);
        send_pixel('1, 16'h0001, '0);
        send_pixel(16'h5555, 16'haaaa, '1);
    endtask

    // equal maxima, red wins over green and green over blue
    task automatic test_max_ties();
        send_pixel('1, '1, '0);
        send_pixel('0, '1, '1);
        send_pixel(16'h1234, 16'h1234, 16'h0100);
        send_pixel(16'h1234, 16'h0100, 16'h1234);
        send_pixel(16'h0100, 16'h1234, 16'h1234);
    endtask

    // red sector with blue above green, hue wraps past a full turn
    task automatic test_red_wrap();
        send_pixel('1, '0, '1);
        send_pixel('1, '0, 16'h0001);
        send_pixel('1, '0, 16'hfffe);
        send_pixel(16'h0002, '0, 16'h0001);
        send_pixel('1, 16'h7fff, 16'h8000);
    endtask

    // random pixels with random gaps on both sides
    task automatic test_random_pixels(input int count);
        logic [CB-1:0] r, g, b;
        gap_mode   = GAP_NORMAL;
        stall_mode = STALL_NORMAL;
        repeat (count) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    // full rate stream, no idling on either side
    task automatic test_back_to_back(input int count);
        logic [CB-1:0] r, g, b;
        gap_mode   = GAP_NONE;
        stall_mode = STALL_NONE;
        repeat (count) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    // long output stalls fill every stage so the input channel stalls too
    task automatic test_backpressure(input int count);
        logic [CB-1:0] r, g, b;
        gap_mode   = GAP_NONE;
        stall_mode = STALL_HEAVY;
        repeat (count) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_max_ties();
        test_red_wrap();
        test_random_pixels(250);
        test_back_to_back(120);
        test_backpressure(130);
        test_random_pixels(100);

        i_valid <= 1'b0;
        // let the pipeline drain, then watch for stray results
        stall_mode = STALL_NORMAL;
        while (pending_hsv.size() != 0) @(posedge i_clk);
        repeat (2 * NUM_STAGES) @(posedge i_clk);

        $display("summary: %0d pixels sent, %0d results checked, %0d grey", sent_count,
                 checked_count, flat_count);
        $display("summary: red/green/blue sectors %0d/%0d/%0d, %0d input stall cycles",
                 sector_count[SEC_RED], sector_count[SEC_GREEN], sector_count[SEC_BLUE],
                 in_stall_cycles);
        if (mismatch_count == 0 && pending_hsv.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
